>>> rtl/hamming_sec_encode_decode_macros.svh
// assertion macros for the hamming encoder/decoder checker
`ifndef HAMMING_SEC_ENCODE_DECODE_MACROS_SVH
`define HAMMING_SEC_ENCODE_DECODE_MACROS_SVH

// same-cycle implication, disabled in reset
`define HSE_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> cons) \
		else $error("hamming check failed");

// next-cycle implication, disabled in reset
`define HSE_ASSERT_NXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> cons) \
		else $error("hamming check failed");

`endif

>>> rtl/hse_pkg.sv
// shared types, constants and geometry functions for the hamming codec
package hse_pkg;

	localparam int MSG_W   = 57;
	localparam int CFG_W   = 6;
	localparam int POS_W   = 6;
	localparam int GEO_N_W = 7;
	localparam int APB_DW  = 32;
	localparam int APB_AW  = 3;

	localparam logic REQ_DECODE = 1'b1;
	localparam logic REG_MSG_LEN = 1'b0;
	localparam logic [CFG_W-1:0] MSG_LEN_RESET = 6'd4;

	typedef struct packed {
		logic [CFG_W-1:0]   k;
		logic [GEO_N_W-1:0] n;
	} geom_t;

	// parity bit count for k message bits
	function automatic logic [2:0] par_bits(input logic [CFG_W-1:0] k);
		logic [2:0] r;
		priority if (k <= 6'd1) r = 3'd2;
		else if (k <= 6'd4)  r = 3'd3;
		else if (k <= 6'd11) r = 3'd4;
		else if (k <= 6'd26) r = 3'd5;
		else if (k <= 6'd57) r = 3'd6;
		else                 r = 3'd7;
		return r;
	endfunction

	// largest message length whose code fits in max_bits
	function automatic logic [CFG_W-1:0] max_msg_len(input int max_bits);
		logic [CFG_W-1:0] res;
		res = 6'd1;
		for (int k = 1; k < 64; k++) begin
			if (k + int'(par_bits(6'(k))) <= max_bits) res = 6'(k);
		end
		return res;
	endfunction

	function automatic geom_t geom_of(input logic [CFG_W-1:0] raw,
		input logic [CFG_W-1:0] kmax);
		logic [CFG_W-1:0] k;
		geom_t g;
		k = (raw == '0) ? 6'd1 : raw;
		if (k > kmax) k = kmax;
		g.k = k;
		g.n = 7'(k) + 7'(par_bits(k));
		return g;
	endfunction

	// 1-based code position of message bit m
	function automatic int data_pos(input int m);
		int cnt;
		int res;
		cnt = -1;
		res = 0;
		for (int p = 1; p < 128; p++) begin
			if ((p & (p - 1)) != 0) begin
				cnt++;
				if (cnt == m && res == 0) res = p;
			end
		end
		return res;
	endfunction

endpackage

>>> rtl/hse_cfg.sv
// apb register for the message length and the derived code geometry
module hse_cfg #(
	parameter int MAX_CODE_BITS = 64
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [hse_pkg::APB_AW-1:0]  paddr,
	input  logic [hse_pkg::APB_DW-1:0]  pwdata,
	output logic [hse_pkg::APB_DW-1:0]  prdata,
	output logic                        pready,
	output hse_pkg::geom_t              geom
);
	import hse_pkg::*;

	localparam logic [CFG_W-1:0] KMAX = max_msg_len(MAX_CODE_BITS);

	logic [CFG_W-1:0] len_q;
	geom_t            geom_q;
	logic             sel_len;
	logic             wr_en;

	assign sel_len = (paddr[APB_AW-1] == REG_MSG_LEN);
	assign wr_en   = psel && penable && pwrite && sel_len;
	assign pready  = 1'b1;
	assign prdata  = sel_len ? {{(APB_DW-CFG_W){1'b0}}, len_q} : '0;
	assign geom    = geom_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q  <= MSG_LEN_RESET;
			geom_q <= geom_of(MSG_LEN_RESET, KMAX);
		end else if (wr_en) begin
			len_q  <= pwdata[CFG_W-1:0];
			geom_q <= geom_of(pwdata[CFG_W-1:0], KMAX);
		end
	end

endmodule

>>> rtl/hse_codec.sv
// combinational encode and syndrome decode/correct datapath
module hse_codec #(
	parameter int MAX_CODE_BITS = 64
) (
	input  hse_pkg::geom_t             geom,
	input  logic                       req_type,
	input  logic [hse_pkg::MSG_W-1:0]  message,
	input  logic [MAX_CODE_BITS-1:0]   received_word,
	output logic [MAX_CODE_BITS-1:0]   code_word,
	output logic [hse_pkg::POS_W-1:0]  error_position,
	output logic                       error_found,
	output logic                       position_invalid
);
	import hse_pkg::*;

	localparam int SW = $clog2(MAX_CODE_BITS + 1);

	logic                     dec;
	logic [MAX_CODE_BITS-1:0] scat;
	logic [MAX_CODE_BITS-1:0] mask;
	logic [MAX_CODE_BITS-1:0] work;
	logic [MAX_CODE_BITS-1:0] flip;
	logic [MAX_CODE_BITS-1:0] par;
	logic [SW-1:0]            synd;

	assign dec = (req_type == REQ_DECODE);

	always_comb begin
		scat = '0;
		for (int m = 0; m < MSG_W; m++) begin
			if (data_pos(m) <= MAX_CODE_BITS)
				scat[data_pos(m)-1] = message[m] & (geom.k > 6'(m));
		end
		for (int p = 0; p < MAX_CODE_BITS; p++) begin
			mask[p] = (geom.n > GEO_N_W'(p));
		end
		work = dec ? (received_word & mask) : scat;
		synd = '0;
		for (int b = 0; b < SW; b++) begin
			for (int p = 0; p < MAX_CODE_BITS; p++) begin
				if ((((p + 1) >> b) & 1) != 0) synd[b] = synd[b] ^ work[p];
			end
		end
		for (int p = 0; p < MAX_CODE_BITS; p++) begin
			flip[p] = (synd == SW'(p + 1));
		end
		par = '0;
		for (int i = 0; i < SW; i++) begin
			if ((1 << i) <= MAX_CODE_BITS) par[(1 << i) - 1] = synd[i];
		end
	end

	assign code_word        = (dec ? (work ^ flip) : (work | par)) & mask;
	assign error_found      = dec && (synd != '0);
	assign position_invalid = dec && (GEO_N_W'(synd) > geom.n);
	assign error_position   = dec ? POS_W'(synd) : '0;

endmodule

>>> rtl/hamming_sec_encode_decode.sv
// top level of the configurable hamming sec encoder/decoder
//
// channel | handshake     | beat
// --------+---------------+------------------------------------------------
// request | start, busy   | req_type, message, received_word
// result  | done          | code_word, error_position, error_found,
//         |               | position_invalid
// config  | apb psel/pen. | message_length at byte address 0
//
// one request per cycle; each result passes the input register, the xor trees and
// the result register before done; busy is never raised
// reset clears the valid flags and sets message_length to 4
// results last one cycle on done; the receiver cannot stall
module hamming_sec_encode_decode #(
	parameter int MAX_CODE_BITS = 64
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	output logic                        busy,
	input  logic                        req_type,
	input  logic [hse_pkg::MSG_W-1:0]   message,
	input  logic [MAX_CODE_BITS-1:0]    received_word,
	output logic                        done,
	output logic [MAX_CODE_BITS-1:0]    code_word,
	output logic [hse_pkg::POS_W-1:0]   error_position,
	output logic                        error_found,
	output logic                        position_invalid,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [hse_pkg::APB_AW-1:0]  paddr,
	input  logic [hse_pkg::APB_DW-1:0]  pwdata,
	output logic [hse_pkg::APB_DW-1:0]  prdata,
	output logic                        pready
);
	import hse_pkg::*;

	geom_t                    geom;
	logic                     vld_s1;
	logic                     type_s1;
	logic [MSG_W-1:0]         msg_s1;
	logic [MAX_CODE_BITS-1:0] rx_s1;
	logic [MAX_CODE_BITS-1:0] cw_c;
	logic [POS_W-1:0]         pos_c;
	logic                     found_c;
	logic                     inval_c;
	logic                     vld_s2;
	logic [MAX_CODE_BITS-1:0] cw_s2;
	logic [POS_W-1:0]         pos_s2;
	logic                     found_s2;
	logic                     inval_s2;

	assign busy = 1'b0;

	hse_cfg #(.MAX_CODE_BITS(MAX_CODE_BITS)) u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.geom    (geom)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
		end else begin
			vld_s1 <= start && !busy;
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (start && !busy) begin
			type_s1 <= req_type;
			msg_s1  <= message;
			rx_s1   <= received_word;
		end
		if (vld_s1) begin
			cw_s2    <= cw_c;
			pos_s2   <= pos_c;
			found_s2 <= found_c;
			inval_s2 <= inval_c;
		end
	end

	hse_codec #(.MAX_CODE_BITS(MAX_CODE_BITS)) u_codec (
		.geom             (geom),
		.req_type         (type_s1),
		.message          (msg_s1),
		.received_word    (rx_s1),
		.code_word        (cw_c),
		.error_position   (pos_c),
		.error_found      (found_c),
		.position_invalid (inval_c)
	);

	assign done             = vld_s2;
	assign code_word        = cw_s2;
	assign error_position   = pos_s2;
	assign error_found      = found_s2;
	assign position_invalid = inval_s2;

endmodule

>>> rtl/hse_checker.sv
// port-level assertions for the hamming codec, bound to the top level
`include "hamming_sec_encode_decode_macros.svh"

module hse_checker (
	input logic                      clk,
	input logic                      arst_n,
	input logic                      start,
	input logic                      busy,
	input logic                      done,
	input logic [hse_pkg::POS_W-1:0] error_position,
	input logic                      error_found,
	input logic                      position_invalid
);

	`HSE_ASSERT_IMP(a_req_gives_result, start && !busy, ##2 done)
	`HSE_ASSERT_IMP(a_no_spurious_result, !$past(start && !busy, 2), !done)
	`HSE_ASSERT_IMP(a_invalid_is_error, done && position_invalid, error_found)
	`HSE_ASSERT_IMP(a_clean_zero_pos, done && !error_found,
		!position_invalid && error_position == '0)

endmodule

bind hamming_sec_encode_decode hse_checker u_hse_checker (
	.clk              (clk),
	.arst_n           (arst_n),
	.start            (start),
	.busy             (busy),
	.done             (done),
	.error_position   (error_position),
	.error_found      (error_found),
	.position_invalid (position_invalid)
);

>>> verif/tb_hamming_sec_encode_decode.sv
// self-checking testbench for the configurable hamming sec encoder/decoder
module tb_hamming_sec_encode_decode;
	timeunit 1ns;
	timeprecision 1ps;
	import hse_pkg::*;

	localparam int CODE_BITS = 64;
	localparam int RESULT_LATENCY = 4;
	localparam int CYCLE_LIMIT = 400000;
	localparam logic REQ_ENCODE = ~REQ_DECODE;
	localparam logic [APB_AW-1:0] MSG_LEN_ADDR = APB_AW'(4 * int'(REG_MSG_LEN));

	typedef struct packed {
		logic [CODE_BITS-1:0] word;
		logic [POS_W-1:0] pos;
		logic found;
		logic invalid;
	} codec_result_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic busy;
	logic req_type = 1'b0;
	logic [MSG_W-1:0] message = '0;
	logic [CODE_BITS-1:0] received_word = '0;
	logic done;
	logic [CODE_BITS-1:0] code_word;
	logic [POS_W-1:0] error_position;
	logic error_found;
	logic position_invalid;
	logic psel = 1'b0;
	logic penable = 1'b0;
	logic pwrite = 1'b0;
	logic [APB_AW-1:0] paddr = '0;
	logic [APB_DW-1:0] pwdata = '0;
	logic [APB_DW-1:0] prdata;
	logic pready;

	logic [CFG_W-1:0] length_reg = MSG_LEN_RESET;
	codec_result_t expected_q[$];
	codec_result_t head;
	int errors = 0;
	int cycles = 0;
	int n_encode = 0;
	int n_decode = 0;
	int n_corrected = 0;
	int n_invalid = 0;
	int n_settings = 0;

	hamming_sec_encode_decode #(.MAX_CODE_BITS(CODE_BITS)) dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.req_type(req_type),
		.message(message),
		.received_word(received_word),
		.done(done),
		.code_word(code_word),
		.error_position(error_position),
		.error_found(error_found),
		.position_invalid(position_invalid),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready)
	);

	always #1 clk = ~clk;

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("CHECK FAILED");
			$finish;
		end
	end

	function automatic void code_geometry(input logic [CFG_W-1:0] len, output int k,
		output int r);
		k = (len == '0) ? 1 : int'(len);
		forever begin
			r = 0;
			while ((1 << r) < k + r + 1) r++;
			if (k > 1 && k + r > CODE_BITS) k--;
			else break;
		end
	endfunction

	function automatic codec_result_t predict_codec(input logic kind,
		input logic [MSG_W-1:0] msg, input logic [CODE_BITS-1:0] rx,
		input logic [CFG_W-1:0] len);
		codec_result_t res;
		int k, r, n, m, s;
		logic [CODE_BITS-1:0] mask;
		code_geometry(len, k, r);
		n = k + r;
		mask = {CODE_BITS{1'b1}} >> (CODE_BITS - n);
		res = '0;
		if (kind == REQ_ENCODE) begin
			m = 0;
			for (int p = 1; p <= n; p++) begin
				if ((p & (p - 1)) != 0) begin
					if (m < k) res.word[p-1] = msg[m];
					m++;
				end
			end
		end else begin
			res.word = rx & mask;
		end
		s = 0;
		for (int p = 1; p <= n; p++)
			if (res.word[p-1]) s ^= p;
		if (kind == REQ_ENCODE) begin
			for (int i = 0; i < r; i++)
				if (((s >> i) & 1) != 0) res.word[(1 << i) - 1] = 1'b1;
		end else begin
			res.pos = POS_W'(s);
			res.found = (s != 0);
			if (s > n) res.invalid = 1'b1;
			else if (s != 0) res.word[s-1] = ~res.word[s-1];
		end
		return res;
	endfunction

	function automatic logic [CODE_BITS-1:0] clean_word(input logic [MSG_W-1:0] msg);
		codec_result_t res;
		res = predict_codec(REQ_ENCODE, msg, '0, length_reg);
		return res.word;
	endfunction

	function automatic logic [CODE_BITS-1:0] rand_word();
		return {$urandom(), $urandom()};
	endfunction

	// result check and expectation capture
	always @(posedge clk) begin
		if (arst_n) begin
			if (done) begin
				if (expected_q.size() == 0) begin
					$display("%0t: unexpected result, expected none, got code_word %h",
						$time, code_word);
					errors++;
				end else begin
					head = expected_q.pop_front();
					if (code_word !== head.word) begin
						$display("%0t: code_word expected %h, got %h", $time, head.word,
							code_word);
						errors++;
					end
					if (error_position !== head.pos) begin
						$display("%0t: error_position expected %0d, got %0d", $time,
							head.pos, error_position);
						errors++;
					end
					if (error_found !== head.found) begin
						$display("%0t: error_found expected %b, got %b", $time,
							head.found, error_found);
						errors++;
					end
					if (position_invalid !== head.invalid) begin
						$display("%0t: position_invalid expected %b, got %b", $time,
							head.invalid, position_invalid);
						errors++;
					end
				end
			end
			if (start && !busy) begin
				head = predict_codec(req_type, message, received_word, length_reg);
				expected_q.insert(expected_q.size(), head);
				if (req_type == REQ_DECODE) begin
					n_decode++;
					if (head.invalid) n_invalid++;
					else if (head.found) n_corrected++;
				end else begin
					n_encode++;
				end
			end
		end
	end

	task automatic send_request(input logic kind, input logic [MSG_W-1:0] msg,
		input logic [CODE_BITS-1:0] word);
		start <= 1'b1;
		req_type <= kind;
		message <= msg;
		received_word <= word;
		do @(posedge clk); while (busy);
	endtask

	task automatic encode_beat(input logic [MSG_W-1:0] msg);
		send_request(REQ_ENCODE, msg, rand_word());
	endtask

	task automatic decode_beat(input logic [CODE_BITS-1:0] word);
		send_request(REQ_DECODE, MSG_W'(rand_word()), word);
	endtask

	task automatic pause_sender(input int n_cycles);
		start <= 1'b0;
		repeat (n_cycles) @(posedge clk);
	endtask

	task automatic wait_results_drained();
		start <= 1'b0;
		do @(posedge clk); while (expected_q.size() != 0);
		repeat (RESULT_LATENCY) @(posedge clk);
	endtask

	task automatic read_length(input logic [CFG_W-1:0] want);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= MSG_LEN_ADDR;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		if (prdata[CFG_W-1:0] !== want) begin
			$display("%0t: message_length readback expected %0d, got %0d", $time, want,
				prdata[CFG_W-1:0]);
			errors++;
		end
		psel <= 1'b0;
		penable <= 1'b0;
	endtask

	task automatic set_length(input logic [CFG_W-1:0] len);
		wait_results_drained();
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= MSG_LEN_ADDR;
		pwdata <= {(APB_DW - CFG_W)'($urandom_range(0, (1 << (APB_DW - CFG_W)) - 1)),
			len};
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		length_reg = len;
		n_settings++;
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		@(posedge clk);
		read_length(len);
	endtask

	task automatic test_reset_length();
		logic [CODE_BITS-1:0] cw;
		read_length(MSG_LEN_RESET);
		encode_beat('0);
		encode_beat('1);
		cw = clean_word(MSG_W'(4'b1010));
		cw[2] = ~cw[2];
		decode_beat(cw);
	endtask

	task automatic test_longest_code();
		logic [CODE_BITS-1:0] cw;
		set_length(6'd57);
		encode_beat('0);
		encode_beat('1);
		encode_beat(MSG_W'(1) << (MSG_W - 1));
		decode_beat('1);
		decode_beat('0);
		cw = clean_word(MSG_W'(rand_word()));
		cw[62] = ~cw[62];
		decode_beat(cw);
	endtask

	task automatic test_length_clamp();
		set_length(6'd0);
		encode_beat(MSG_W'(1));
		decode_beat(CODE_BITS'(3'b111));
		set_length(6'd63);
		encode_beat('1);
		decode_beat(CODE_BITS'(1) << (CODE_BITS - 1));
	endtask

	task automatic test_syndrome_overrun();
		set_length(6'd5);
		decode_beat(CODE_BITS'(1) << 6 | CODE_BITS'(1) << 7);
		decode_beat(CODE_BITS'(1) << 8 | CODE_BITS'(1));
		set_length(6'd11);
		decode_beat(rand_word());
	endtask

	task automatic test_single_errors();
		logic [CODE_BITS-1:0] cw;
		int flip_at[4];
		set_length(6'd26);
		flip_at = '{1, 2, 16, 31};
		foreach (flip_at[i]) begin
			cw = clean_word(MSG_W'(rand_word()));
			cw[flip_at[i]-1] = ~cw[flip_at[i]-1];
			decode_beat(cw);
		end
	endtask

	// encodes mixed with mostly valid words with zero, one or two flips, some noise
	task automatic test_random_traffic(input logic [CFG_W-1:0] len, input int n_items);
		int k, r, n, sent, burst, kind, a, b;
		logic [CODE_BITS-1:0] cw, mask;
		set_length(len);
		code_geometry(len, k, r);
		n = k + r;
		mask = {CODE_BITS{1'b1}} >> (CODE_BITS - n);
		sent = 0;
		while (sent < n_items) begin
			burst = $urandom_range(1, 24);
			while (burst > 0 && sent < n_items) begin
				kind = $urandom_range(0, 99);
				if (kind < 35) begin
					encode_beat(MSG_W'(rand_word()));
				end else if (kind < 90) begin
					cw = clean_word(MSG_W'(rand_word()));
					a = $urandom_range(1, n);
					b = $urandom_range(1, n);
					if (kind < 80) cw[a-1] = ~cw[a-1];
					else if (kind < 85 && a != b) cw = cw ^ (CODE_BITS'(1) << (a - 1))
						^ (CODE_BITS'(1) << (b - 1));
					if ($urandom_range(0, 4) == 0) cw = cw | (rand_word() & ~mask);
					decode_beat(cw);
				end else begin
					decode_beat(rand_word());
				end
				sent++;
				burst--;
				if (sent == n_items / 2 && len == 6'd11) wait_results_drained();
			end
			if ($urandom_range(0, 9) < 7) pause_sender($urandom_range(1, 6));
		end
	endtask

	initial begin
		logic [CFG_W-1:0] lengths[10];
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_reset_length();
		test_longest_code();
		test_length_clamp();
		test_syndrome_overrun();
		test_single_errors();
		lengths = '{6'd1, 6'd57, 6'd63, 6'd0, 6'd4, 6'd11, 6'd26, 6'd5,
			CFG_W'($urandom_range(0, 63)), CFG_W'($urandom_range(0, 63))};
		foreach (lengths[i]) test_random_traffic(lengths[i], 160);
		wait_results_drained();
		$display("%0d beats checked: %0d encode, %0d decode (%0d corrected, %0d out of range)",
			n_encode + n_decode, n_encode, n_decode, n_corrected, n_invalid);
		$display("%0d message length settings, including 0, 1, 57 and 63", n_settings);
		if (errors == 0 && expected_q.size() == 0) begin
			$display("CHECK OK");
		end else begin
			$display("CHECK FAILED");
		end
		$finish;
	end

endmodule
